FILE: rtl/core/les_pkg.sv
// Shared constants, types and a helper function of the largest empty square unit.
`timescale 1ns / 1ps
package les_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 65536;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int WIDTH_W = COL_W + 1;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int SIZE_W  = 11;
    localparam int CHAR_W  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WIDTH_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CHAR = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET  = WIDTH_W'(MAX_COLS);
    localparam logic [CHAR_W-1:0]  EMPTY_CHAR_RESET = CHAR_W'(46);

    localparam logic [SIZE_W-1:0] SIZE_MAX  = {SIZE_W{1'b1}};
    localparam logic [ROW_W-1:0]  ROW_LIMIT = ROW_W'(MAX_ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LIMIT = COL_W'(MAX_COLS - 1);

    typedef logic [SIZE_W-1:0] les_size_t;
    typedef logic [ROW_W-1:0]  les_row_t;
    typedef logic [COL_W-1:0]  les_col_t;
    typedef logic [CHAR_W-1:0] les_char_t;

    typedef struct packed {
        les_size_t size;
        les_row_t  row;
        les_col_t  col;
    } les_result_t;

    function automatic les_col_t les_width_m1(input logic [WIDTH_W-1:0] row_width);
        les_col_t last_col;
        if (row_width == '0)
        begin
            last_col = '0;
        end
        else if (row_width > WIDTH_W'(MAX_COLS))
        begin
            last_col = COL_LIMIT;
        end
        else
        begin
            last_col = COL_W'(row_width - WIDTH_W'(1));
        end
        return last_col;
    endfunction

endpackage

FILE: rtl/core/les_if.sv
// Handshake interfaces for the cell input, result output and configuration channels.
`timescale 1ns / 1ps
interface les_cell_if;
    logic                valid;
    logic                ready;
    les_pkg::les_char_t  cell_char;
    logic                last_cell;

    modport source (output valid, output cell_char, output last_cell, input ready);
    modport sink (input valid, input cell_char, input last_cell, output ready);
endinterface

interface les_result_if;
    logic                valid;
    logic                ready;
    les_pkg::les_size_t  square_size;
    les_pkg::les_row_t   corner_row;
    les_pkg::les_col_t   corner_col;

    modport source (output valid, output square_size, output corner_row,
                    output corner_col, input ready);
    modport sink (input valid, input square_size, input corner_row,
                  input corner_col, output ready);
endinterface

interface les_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [les_pkg::CFG_IDX_W-1:0]         index;
    logic [les_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/largest_empty_square_unit.sv
// Top level of the streaming largest empty square finder.
// The unit takes one grid cell per clock cycle in raster order and answers with the side
// and bottom-right corner of the largest square of empty cells once the cell marked last
// arrives, the first such square found winning ties. Each cell is sized in the cycle it is
// accepted; the previous row's sizes live in a delay chain of MAX_COLS cells whose entry
// cell is chosen by the row width, so the value for the same column of the previous row
// leaves the chain exactly one row later. Results pass through a two-entry output buffer,
// so input is stalled only when two results wait unread. The line store needs no clearing
// after reset, and row width and empty character should be changed between grids.
`timescale 1ns / 1ps
module largest_empty_square_unit (
    input logic        clk,
    input logic        rst_n,
    les_cell_if.sink   cell_in,
    les_result_if.source result_out,
    les_cfg_if.sink    cfg
);
    import les_pkg::*;

    logic [WIDTH_W-1:0] row_width_reg;
    les_char_t          empty_char_reg;

    les_size_t   up_size, new_size;
    logic        accept, result_fire, pop;
    les_result_t result;

    les_result_t head_reg, tail_reg;
    logic [1:0]  count_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= ROW_WIDTH_RESET;
            empty_char_reg <= EMPTY_CHAR_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_ROW_WIDTH:  row_width_reg  <= cfg.data;
                REG_EMPTY_CHAR: empty_char_reg <= cfg.data[CHAR_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cell_in.ready = (count_reg != 2'd2);
    assign accept        = cell_in.valid && cell_in.ready;

    les_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cell_char   (cell_in.cell_char),
        .last_cell   (cell_in.last_cell),
        .row_width   (row_width_reg),
        .empty_char  (empty_char_reg),
        .up_size     (up_size),
        .new_size    (new_size),
        .result_fire (result_fire),
        .result      (result)
    );

    les_line u_line (
        .clk       (clk),
        .shift_en  (accept),
        .row_width (row_width_reg),
        .new_size  (new_size),
        .up_size   (up_size)
    );

    assign pop = result_out.valid && result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (result_fire && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !result_fire)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (result_fire && count_reg == 2'd1)
            begin
                head_reg <= result;
            end
            else
            begin
                head_reg <= tail_reg;
            end
            if (result_fire && count_reg == 2'd2)
            begin
                tail_reg <= result;
            end
        end
        else if (result_fire)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= result;
            end
            else
            begin
                tail_reg <= result;
            end
        end
    end

    assign result_out.valid       = (count_reg != 2'd0);
    assign result_out.square_size = head_reg.size;
    assign result_out.corner_row  = head_reg.row;
    assign result_out.corner_col  = head_reg.col;
endmodule

FILE: rtl/core/les_cell.sv
// One stage of the line store delay chain, holding the size of one column.
`timescale 1ns / 1ps
module les_cell (
    input  logic               clk,
    input  logic               shift_en,
    input  logic               load_sel,
    input  les_pkg::les_size_t from_next,
    input  les_pkg::les_size_t load_data,
    output les_pkg::les_size_t q
);
    import les_pkg::*;

    les_size_t q_reg;
    les_size_t q_next;

    always_comb
    begin
        q_next = load_sel ? load_data : from_next;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule

FILE: rtl/core/les_line.sv
// Line store built as a delay chain of cells whose entry point follows the row width.
`timescale 1ns / 1ps
module les_line (
    input  logic                          clk,
    input  logic                          shift_en,
    input  logic [les_pkg::WIDTH_W-1:0]   row_width,
    input  les_pkg::les_size_t            new_size,
    output les_pkg::les_size_t            up_size
);
    import les_pkg::*;

    les_size_t cell_q [MAX_COLS];
    les_col_t  entry_col;

    assign entry_col = les_width_m1(row_width);

    for (genvar i = 0; i < MAX_COLS; i++)
    begin : g_cell
        les_size_t from_next;

        if (i == MAX_COLS - 1)
        begin : g_end
            assign from_next = '0;
        end
        else
        begin : g_mid
            assign from_next = cell_q[i + 1];
        end

        les_cell u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .load_sel  (entry_col == COL_W'(i)),
            .from_next (from_next),
            .load_data (new_size),
            .q         (cell_q[i])
        );
    end

    assign up_size = cell_q[0];
endmodule

FILE: rtl/core/les_track.sv
// Per-cell square size, raster position and running best answer of the grid.
`timescale 1ns / 1ps
module les_track (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  les_pkg::les_char_t            cell_char,
    input  logic                          last_cell,
    input  logic [les_pkg::WIDTH_W-1:0]   row_width,
    input  les_pkg::les_char_t            empty_char,
    input  les_pkg::les_size_t            up_size,
    output les_pkg::les_size_t            new_size,
    output logic                          result_fire,
    output les_pkg::les_result_t          result
);
    import les_pkg::*;

    les_size_t left_reg, left_next;
    les_size_t diag_reg, diag_next;
    les_col_t  col_reg, col_next;
    les_row_t  row_reg, row_next;
    les_size_t best_size_reg, best_size_next;
    les_row_t  best_row_reg, best_row_next;
    les_col_t  best_col_reg, best_col_next;

    les_size_t left_v, diag_v, up_v, min_v, size_v;
    logic [SIZE_W:0] sum_v;
    logic      is_empty, better, end_row;
    les_col_t  last_col;

    always_comb
    begin
        last_col = les_width_m1(row_width);
        left_v   = (col_reg != '0) ? left_reg : '0;
        diag_v   = (col_reg != '0 && row_reg != '0) ? diag_reg : '0;
        up_v     = (row_reg != '0) ? up_size : '0;
        min_v    = left_v;
        if (diag_v < min_v)
        begin
            min_v = diag_v;
        end
        if (up_v < min_v)
        begin
            min_v = up_v;
        end
        sum_v    = {1'b0, min_v} + (SIZE_W + 1)'(1);
        is_empty = (cell_char == empty_char);
        if (!is_empty)
        begin
            size_v = '0;
        end
        else if (sum_v > {1'b0, SIZE_MAX})
        begin
            size_v = SIZE_MAX;
        end
        else
        begin
            size_v = sum_v[SIZE_W-1:0];
        end
        better  = is_empty && (size_v > best_size_reg);
        end_row = (col_reg >= last_col);

        best_size_next = better ? size_v : best_size_reg;
        best_row_next  = better ? row_reg : best_row_reg;
        best_col_next  = better ? col_reg : best_col_reg;
        result.size    = best_size_next;
        result.row     = best_row_next;
        result.col     = best_col_next;

        left_next = size_v;
        diag_next = up_v;
        col_next  = col_reg + COL_W'(1);
        row_next  = row_reg;
        if (end_row)
        begin
            col_next  = '0;
            left_next = '0;
            diag_next = '0;
            if (row_reg < ROW_LIMIT)
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
        if (last_cell)
        begin
            left_next      = '0;
            diag_next      = '0;
            col_next       = '0;
            row_next       = '0;
            best_size_next = '0;
            best_row_next  = '0;
            best_col_next  = '0;
        end
    end

    assign new_size    = size_v;
    assign result_fire = accept && last_cell;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end
        else if (accept)
        begin
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            best_size_reg <= best_size_next;
            best_row_reg  <= best_row_next;
            best_col_reg  <= best_col_next;
        end
    end
endmodule

FILE: rtl/core/les_chk.sv
// Port-level assertions for the largest empty square unit and their binding.
`timescale 1ns / 1ps
module les_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input les_pkg::les_size_t square_size,
    input les_pkg::les_row_t  corner_row,
    input les_pkg::les_col_t  corner_col
);
    import les_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(square_size) && $stable(corner_row)
            && $stable(corner_col))
        else $error("stalled result beat changed");

    a_full_means_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && square_size == '0 |-> corner_row == '0 && corner_col == '0)
        else $error("corner reported for a grid with no empty cell");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> square_size <= SIZE_W'(MAX_COLS))
        else $error("square wider than the largest row");
endmodule

bind largest_empty_square_unit les_chk u_les_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (cell_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .square_size (result_out.square_size),
    .corner_row  (result_out.corner_row),
    .corner_col  (result_out.corner_col)
);
